### sv/qvr_pkg.sv
package qvr_pkg;

	// Field widths of the block's ports.
	localparam int WORD_W = 32;

	// A product of two 32-bit words.
	localparam int PROD_W = 64;

	// Sums of up to four 32x32 products (dot product, w*w - u.u, cross product).
	localparam int WIDE_W = 65;

	// Low half of a wide operand; the high half has WIDE_W - LO_W bits.
	localparam int LO_W = 32;

	// One partial product: 33-bit by 32-bit signed.
	localparam int PART_W = 65;

	// One exact triple product with 76 fraction bits.
	localparam int TERM_W = 97;

	// Per-component accumulator; the exact sum stays below 2^98.
	localparam int SUM_W = 99;

	// Fraction bits dropped when going from 76 to 16 fraction bits.
	localparam int FRAC_DROP = 60;

	// Width of the rounded value before saturation.
	localparam int RND_W = SUM_W - FRAC_DROP;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [TERM_W-1:0] term_t;

	localparam word_t SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// One input transaction: quaternion vector part u, scalar w, vector v.
	typedef struct packed {
		word_t [2:0] u;
		word_t       w;
		word_t [2:0] v;
	} qvr_item_t;

	// After the dot and cross products: s = w*w - u.u, d = u.v, c = u x v.
	typedef struct packed {
		wide_t       s;
		wide_t       d;
		wide_t [2:0] c;
		word_t [2:0] u;
		word_t       w;
		word_t [2:0] v;
	} qvr_mid_t;

	// The three exact triple products of each output component.
	typedef struct packed {
		term_t [2:0] sv;
		term_t [2:0] du;
		term_t [2:0] wc;
	} qvr_terms_t;

	// One result transaction.
	typedef struct packed {
		word_t [2:0] res;
		logic        ovf;
	} qvr_result_t;

endpackage

### sv/quaternion_vector_rotate_core.sv
// Rotates a vector by a quaternion as q * (v, 0) * conj(q) and returns the vector part.
// Quaternion components are signed Q2.30 and vectors signed Q16.16; the quaternion is
// not normalized, so a non-unit quaternion also scales the vector by its squared norm.
// Every product and sum is exact; each component is rounded once to nearest (ties
// toward plus infinity) and saturated, and overflow reports that any component hit a
// limit. The core is a six-stage pipeline with no feedback: busy is never raised, so a
// transaction can be started in every clock cycle, and its result is on out_x, out_y,
// out_z and overflow with done high when it reaches the stage 6 registers.
// The result is shown for one cycle only, since the receiver cannot stall; it must
// capture it then. Throughput is one vector per cycle, set by the fully pipelined
// multiplier array (32x32 products for the dot and cross products, then 33x32 partial
// products for the scaling by w and by the dot terms).
module quaternion_vector_rotate_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [31:0]    quat_x,
	input  logic signed [31:0]    quat_y,
	input  logic signed [31:0]    quat_z,
	input  logic signed [31:0]    quat_w,
	input  logic signed [31:0]    vec_x,
	input  logic signed [31:0]    vec_y,
	input  logic signed [31:0]    vec_z,
	output logic                  done,
	output logic signed [31:0]    out_x,
	output logic signed [31:0]    out_y,
	output logic signed [31:0]    out_z,
	output logic                  overflow
);

	qvr_pkg::qvr_item_t   item;
	logic                 in_valid;
	logic                 mid_valid;
	qvr_pkg::qvr_mid_t    mid;
	logic                 term_valid;
	qvr_pkg::qvr_terms_t  terms;
	logic                 res_valid;
	qvr_pkg::qvr_result_t result;

	// Nothing ever holds the pipeline back, so every start is a transaction.
	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	assign item.u[0] = quat_x;
	assign item.u[1] = quat_y;
	assign item.u[2] = quat_z;
	assign item.w    = quat_w;
	assign item.v[0] = vec_x;
	assign item.v[1] = vec_y;
	assign item.v[2] = vec_z;

	// Stages 1 and 2: w*w - u.u, u.v and u x v.
	qvr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_item   (item),
		.mid_valid (mid_valid),
		.mid       (mid)
	);

	// Stages 3 and 4: the three exact triple products of each component.
	qvr_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.mid_valid  (mid_valid),
		.mid        (mid),
		.term_valid (term_valid),
		.terms      (terms)
	);

	// Stages 5 and 6: sum, round to Q16.16 and saturate.
	qvr_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_valid (term_valid),
		.terms      (terms),
		.res_valid  (res_valid),
		.result     (result)
	);

	assign done     = res_valid;
	assign out_x    = result.res[0];
	assign out_y    = result.res[1];
	assign out_z    = result.res[2];
	assign overflow = result.ovf;

	// A transaction reaches the sum stage only after it was started and passed stage 1.
	a_mid_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		mid_valid |-> $past(in_valid, 2))
		else $error("sum stage valid without a started transaction");

	// The back half of the pipeline does not invent transactions.
	a_done_follows_mid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(mid_valid, 4))
		else $error("result strobe without a transaction in the sum stage");

	// Overflow is only reported together with a saturated component.
	a_ovf_means_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |->
			(out_x == qvr_pkg::SAT_MAX || out_x == qvr_pkg::SAT_MIN
			|| out_y == qvr_pkg::SAT_MAX || out_y == qvr_pkg::SAT_MIN
			|| out_z == qvr_pkg::SAT_MAX || out_z == qvr_pkg::SAT_MIN))
		else $error("overflow flagged but no component is at a limit");

endmodule

### sv/qvr_front.sv
module qvr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  qvr_pkg::qvr_item_t in_item,
	output logic              mid_valid,
	output qvr_pkg::qvr_mid_t  mid
);

	// Stage 1: all 32x32 products of w*w and of the dot and cross products.
	logic                                 valid_s1;
	qvr_pkg::qvr_item_t                   item_s1;
	logic signed [qvr_pkg::PROD_W-1:0]    ww_s1;
	logic signed [qvr_pkg::PROD_W-1:0]    uu_s1 [3];
	logic signed [qvr_pkg::PROD_W-1:0]    uv_s1 [3];
	logic signed [qvr_pkg::PROD_W-1:0]    cp_s1 [3];
	logic signed [qvr_pkg::PROD_W-1:0]    cm_s1 [3];

	// Stage 2: sums of those products.
	logic                                 valid_s2;
	qvr_pkg::qvr_mid_t                    mid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		ww_s1   <= $signed(in_item.w) * $signed(in_item.w);
	end

	for (genvar i = 0; i < 3; i++) begin : g_prod
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			uu_s1[i] <= $signed(in_item.u[i]) * $signed(in_item.u[i]);
			uv_s1[i] <= $signed(in_item.u[i]) * $signed(in_item.v[i]);
			cp_s1[i] <= $signed(in_item.u[J]) * $signed(in_item.v[K]);
			cm_s1[i] <= $signed(in_item.u[K]) * $signed(in_item.v[J]);
		end
		always_ff @(posedge clk) begin
			mid_s2.c[i] <= qvr_pkg::wide_t'(cp_s1[i]) - qvr_pkg::wide_t'(cm_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		mid_s2.s <= qvr_pkg::wide_t'(ww_s1) - qvr_pkg::wide_t'(uu_s1[0])
			- qvr_pkg::wide_t'(uu_s1[1]) - qvr_pkg::wide_t'(uu_s1[2]);
		mid_s2.d <= qvr_pkg::wide_t'(uv_s1[0]) + qvr_pkg::wide_t'(uv_s1[1])
			+ qvr_pkg::wide_t'(uv_s1[2]);
		mid_s2.u <= item_s1.u;
		mid_s2.w <= item_s1.w;
		mid_s2.v <= item_s1.v;
	end

	assign mid_valid = valid_s2;
	assign mid       = mid_s2;

endmodule

### sv/qvr_scale.sv
module qvr_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mid_valid,
	input  qvr_pkg::qvr_mid_t  mid,
	output logic               term_valid,
	output qvr_pkg::qvr_terms_t terms
);

	localparam int HI_W = qvr_pkg::WIDE_W - qvr_pkg::LO_W;

	typedef logic signed [qvr_pkg::PART_W-1:0] part_t;

	// Stage 3: each wide-by-word product as two 33x32 partial products.
	logic   valid_s3;
	part_t  sv_hi_s3 [3];
	part_t  sv_lo_s3 [3];
	part_t  du_hi_s3 [3];
	part_t  du_lo_s3 [3];
	part_t  wc_hi_s3 [3];
	part_t  wc_lo_s3 [3];

	// Stage 4: partial products joined into exact triple products.
	logic                 valid_s4;
	qvr_pkg::qvr_terms_t  terms_s4;

	// The product is formed at the full partial width so that no bits are lost.
	function automatic part_t mul_hi(qvr_pkg::wide_t a, qvr_pkg::word_t b);
		logic signed [HI_W-1:0] ah;
		part_t                  p;
		ah = a[qvr_pkg::WIDE_W-1:qvr_pkg::LO_W];
		p  = ah * $signed(b);
		return p;
	endfunction

	function automatic part_t mul_lo(qvr_pkg::wide_t a, qvr_pkg::word_t b);
		logic signed [qvr_pkg::LO_W:0] al;
		part_t                         p;
		al = {1'b0, a[qvr_pkg::LO_W-1:0]};
		p  = al * $signed(b);
		return p;
	endfunction

	// The high partial carries weight 2^32 over the low one.
	function automatic qvr_pkg::term_t join_parts(part_t hi, part_t lo);
		logic signed [qvr_pkg::TERM_W-1:0] th;
		logic signed [qvr_pkg::TERM_W-1:0] tl;
		th = {hi, {qvr_pkg::LO_W{1'b0}}};
		tl = {{(qvr_pkg::TERM_W-qvr_pkg::PART_W){lo[qvr_pkg::PART_W-1]}}, lo};
		return th + tl;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= mid_valid;
			valid_s4 <= valid_s3;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_comp
		always_ff @(posedge clk) begin
			sv_hi_s3[i] <= mul_hi(mid.s, mid.v[i]);
			sv_lo_s3[i] <= mul_lo(mid.s, mid.v[i]);
			du_hi_s3[i] <= mul_hi(mid.d, mid.u[i]);
			du_lo_s3[i] <= mul_lo(mid.d, mid.u[i]);
			wc_hi_s3[i] <= mul_hi(mid.c[i], mid.w);
			wc_lo_s3[i] <= mul_lo(mid.c[i], mid.w);
		end
		always_ff @(posedge clk) begin
			terms_s4.sv[i] <= join_parts(sv_hi_s3[i], sv_lo_s3[i]);
			terms_s4.du[i] <= join_parts(du_hi_s3[i], du_lo_s3[i]);
			terms_s4.wc[i] <= join_parts(wc_hi_s3[i], wc_lo_s3[i]);
		end
	end

	assign term_valid = valid_s4;
	assign terms      = terms_s4;

endmodule

### sv/qvr_round.sv
module qvr_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                term_valid,
	input  qvr_pkg::qvr_terms_t terms,
	output logic                res_valid,
	output qvr_pkg::qvr_result_t result
);

	typedef logic signed [qvr_pkg::SUM_W-1:0] sum_t;
	typedef logic signed [qvr_pkg::RND_W-1:0] rnd_t;

	localparam sum_t HALF_LSB = sum_t'(1) <<< (qvr_pkg::FRAC_DROP - 1);

	// Stage 5: exact component sums with the rounding half already added.
	logic  valid_s5;
	sum_t  sum_s5 [3];

	// Stage 6: rounded and saturated result.
	logic                  valid_s6;
	qvr_pkg::qvr_result_t  result_s6;

	rnd_t          rnd [3];
	logic [2:0]    sat;
	qvr_pkg::word_t clip [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= term_valid;
			valid_s6 <= valid_s5;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_comp
		always_ff @(posedge clk) begin
			sum_s5[i] <= sum_t'(terms.sv[i]) + (sum_t'(terms.du[i]) <<< 1)
				+ (sum_t'(terms.wc[i]) <<< 1) + HALF_LSB;
		end

		// The value fits when all bits above the result's sign bit match it.
		always_comb begin
			rnd[i] = sum_s5[i][qvr_pkg::SUM_W-1:qvr_pkg::FRAC_DROP];
			sat[i] = (rnd[i][qvr_pkg::RND_W-1:qvr_pkg::WORD_W-1] != '0)
				&& (rnd[i][qvr_pkg::RND_W-1:qvr_pkg::WORD_W-1] != '1);
			if (!sat[i]) begin
				clip[i] = rnd[i][qvr_pkg::WORD_W-1:0];
			end else if (rnd[i][qvr_pkg::RND_W-1]) begin
				clip[i] = qvr_pkg::SAT_MIN;
			end else begin
				clip[i] = qvr_pkg::SAT_MAX;
			end
		end

		always_ff @(posedge clk) begin
			result_s6.res[i] <= clip[i];
		end
	end

	always_ff @(posedge clk) begin
		result_s6.ovf <= |sat;
	end

	assign res_valid = valid_s6;
	assign result    = result_s6;

endmodule
